/* src/cccv_pkg.sv */
// Shared types and constants for the CC/CV charge controller.
// No dependencies; imported by cccv_pi, cc_cv_charge_controller and the testbench.
`default_nettype none

package cccv_pkg;

    // Charger operating modes as reported in the result item.
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_CC   = 2'd1,
        MODE_CV   = 2'd2
    } mode_t;

    // Proportional gain is an unsigned Q0.16 fraction.
    localparam int GAIN_BITS = 16;
    // Rounding offset of one half LSB of the Q0.16 product.
    localparam int ROUND_HALF = 32768;

    // Drive command width and result item layout.
    localparam int DRIVE_BITS = 24;
    localparam int M_DATA_W   = 32;

    // Configuration register map.
    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PROP_GAIN     = 4'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_VOLT_SETPOINT = 4'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_AMP_SETPOINT  = 4'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_END_CURRENT   = 4'd3;

endpackage

`default_nettype wire

/* src/cccv_pi.sv */
// Proportional-plus-integral control law with saturating integrator and drive.
// Depends on cccv_pkg for the gain width, rounding offset and drive width.
`default_nettype none

module cccv_pi
    import cccv_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int ACC_BITS    = 24
) (
    input  wire logic [GAIN_BITS-1:0]          gain,
    input  wire logic [SAMPLE_BITS-1:0]        setpoint,
    input  wire logic [SAMPLE_BITS-1:0]        sample,
    input  wire logic signed [ACC_BITS-1:0]    integ_in,
    output logic signed [ACC_BITS-1:0]         integ_out,
    output logic signed [DRIVE_BITS-1:0]       drive
);

    localparam int EW  = SAMPLE_BITS + 1;                  // error width
    localparam int PW  = GAIN_BITS + SAMPLE_BITS + 2;      // product plus rounding headroom
    localparam int PPW = PW - GAIN_BITS;                   // proportional term width
    localparam int SW  = ((ACC_BITS > EW) ? ACC_BITS : EW) + 1;
    localparam int DW0 = (ACC_BITS > PPW) ? ACC_BITS : PPW;
    localparam int DW  = ((DW0 > DRIVE_BITS) ? DW0 : DRIVE_BITS) + 2;

    logic signed [EW-1:0]  set_s;
    logic signed [EW-1:0]  err;
    logic signed [PW-1:0]  prod;
    logic signed [PW-1:0]  prod_rnd;
    logic signed [PPW-1:0] prop;
    logic signed [SW-1:0]  integ_sum;
    logic signed [DW-1:0]  drive_sum;

    always_comb begin
        set_s    = $signed({1'b0, setpoint});
        err      = set_s - $signed({1'b0, sample});
        prod     = PW'($signed({1'b0, gain})) * PW'(err);
        prod_rnd = prod + PW'(ROUND_HALF);
        // Arithmetic shift by the fraction width rounds toward minus infinity.
        prop     = prod_rnd[PW-1:GAIN_BITS];

        integ_sum = SW'(integ_in) + SW'(err);
        if ((&integ_sum[SW-1:ACC_BITS-1]) || !(|integ_sum[SW-1:ACC_BITS-1])) begin
            integ_out = integ_sum[ACC_BITS-1:0];
        end else begin
            integ_out = {integ_sum[SW-1], {(ACC_BITS-1){~integ_sum[SW-1]}}};
        end

        drive_sum = DW'(set_s) - DW'(prop) - DW'(integ_out);
        if ((&drive_sum[DW-1:DRIVE_BITS-1]) || !(|drive_sum[DW-1:DRIVE_BITS-1])) begin
            drive = drive_sum[DRIVE_BITS-1:0];
        end else begin
            drive = {drive_sum[DW-1], {(DRIVE_BITS-1){~drive_sum[DW-1]}}};
        end
    end

endmodule

`default_nettype wire

/* src/cc_cv_charge_controller.sv */
// Top level of the CC/CV charge controller: stream ports, register file,
// mode sequencer and result register. Depends on cccv_pkg and cccv_pi.
//
//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+------------------------------------------
//  s_       | in        | s_tvalid / s_tready  | s_tdata: enable, volt_sample, amp_sample
//  m_       | out       | m_tvalid / m_tready  | m_tdata: drive_value, drive_valid, mode
//  cfg_     | in        | cfg_valid / cfg_ready| cfg_addr: register index, cfg_data: value
//
// Throughput is one item per clock while m_ is not stalled; an item accepted
// on s_ is held in the input register, then the mode sequencer and the
// single shared PI unit update the state and load the result register in
// the same cycle. The PI multiply and its saturating adds form the longest
// path.
// aresetn is synchronous and active low; it returns the mode to idle, clears
// both integrators and loads the register reset values.
// A stall on m_ holds the result register; the input register still takes
// one more item, and s_tready drops only while both registers are full.

`default_nettype none

module cc_cv_charge_controller
    import cccv_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int ACC_BITS    = 24,
    localparam int S_DATA_W   = ((2 * SAMPLE_BITS + 1 + 7) / 8) * 8
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,

    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // Fields from bit 0 up: enable, volt_sample, amp_sample, zero fill.
    input  wire logic [S_DATA_W-1:0]      s_tdata,

    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // Fields from bit 0 up: drive_value, drive_valid, mode, zero fill.
    output logic [M_DATA_W-1:0]           m_tdata,

    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int OUT_BITS = DRIVE_BITS + 1 + 2;

    // Configuration registers.
    logic [GAIN_BITS-1:0]   prop_gain_reg;
    logic [SAMPLE_BITS-1:0] volt_setpoint_reg;
    logic [SAMPLE_BITS-1:0] amp_setpoint_reg;
    logic [SAMPLE_BITS-1:0] end_current_reg;

    // Input register.
    logic                   in_valid_reg;
    logic                   in_enable_reg;
    logic [SAMPLE_BITS-1:0] in_volt_reg;
    logic [SAMPLE_BITS-1:0] in_amp_reg;

    // Controller state.
    mode_t                  mode_reg;
    mode_t                  mode_next;
    logic signed [ACC_BITS-1:0] volt_integral_reg;
    logic signed [ACC_BITS-1:0] amp_integral_reg;

    // Result register.
    logic                   m_valid_reg;
    logic signed [DRIVE_BITS-1:0] m_drive_reg;
    logic                   m_dvalid_reg;
    mode_t                  m_mode_reg;

    // Datapath between the two registers.
    logic                   advance;
    logic                   regulating;
    logic                   use_cv;
    logic [SAMPLE_BITS-1:0] pi_setpoint;
    logic [SAMPLE_BITS-1:0] pi_sample;
    logic signed [ACC_BITS-1:0]   pi_integ_in;
    logic signed [ACC_BITS-1:0]   pi_integ_out;
    logic signed [DRIVE_BITS-1:0] pi_drive;
    logic signed [DRIVE_BITS-1:0] drive_next;

    // The held item moves on whenever the result register is free or being emptied.
    assign advance   = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Configuration writes; indexes past the register list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg     <= GAIN_BITS'(655);
            volt_setpoint_reg <= SAMPLE_BITS'(3300);
            amp_setpoint_reg  <= SAMPLE_BITS'(1000);
            end_current_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_addr)
                REG_PROP_GAIN:     prop_gain_reg     <= cfg_data;
                REG_VOLT_SETPOINT: volt_setpoint_reg <= cfg_data[SAMPLE_BITS-1:0];
                REG_AMP_SETPOINT:  amp_setpoint_reg  <= cfg_data[SAMPLE_BITS-1:0];
                REG_END_CURRENT:   end_current_reg   <= cfg_data[SAMPLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_enable_reg <= s_tdata[0];
            in_volt_reg   <= s_tdata[SAMPLE_BITS:1];
            in_amp_reg    <= s_tdata[2*SAMPLE_BITS:SAMPLE_BITS+1];
        end
    end

    // Mode sequencer. The drive of a regulating step uses the mode in force
    // before the step; the result reports the mode after it.
    always_comb begin
        mode_next  = mode_reg;
        regulating = 1'b0;
        use_cv     = 1'b0;
        case (mode_reg)
            MODE_CC: begin
                regulating = 1'b1;
                if (in_volt_reg >= volt_setpoint_reg) begin
                    mode_next = MODE_CV;
                end
            end
            MODE_CV: begin
                regulating = 1'b1;
                use_cv     = 1'b1;
                if (in_amp_reg <= end_current_reg) begin
                    mode_next = MODE_IDLE;
                end
            end
            default: begin
                // Idle, and the unused code, only look at the start request.
                mode_next = in_enable_reg ? MODE_CC : MODE_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
        end else if (advance) begin
            mode_reg <= mode_next;
        end
    end

    // One PI unit serves both loops; the mode picks setpoint, sample and integrator.
    assign pi_setpoint = use_cv ? volt_setpoint_reg : amp_setpoint_reg;
    assign pi_sample   = use_cv ? in_volt_reg : in_amp_reg;
    assign pi_integ_in = use_cv ? volt_integral_reg : amp_integral_reg;

    cccv_pi #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_BITS    (ACC_BITS)
    ) u_pi (
        .gain      (prop_gain_reg),
        .setpoint  (pi_setpoint),
        .sample    (pi_sample),
        .integ_in  (pi_integ_in),
        .integ_out (pi_integ_out),
        .drive     (pi_drive)
    );

    assign drive_next = regulating ? pi_drive : '0;

    // Integrators persist across mode changes; only the active one moves.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volt_integral_reg <= '0;
            amp_integral_reg  <= '0;
        end else if (advance && regulating) begin
            if (use_cv) begin
                volt_integral_reg <= pi_integ_out;
            end else begin
                amp_integral_reg  <= pi_integ_out;
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_drive_reg  <= drive_next;
            m_dvalid_reg <= regulating;
            m_mode_reg   <= mode_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W-OUT_BITS){1'b0}}, m_mode_reg, m_dvalid_reg, m_drive_reg};

    // An idle step reports no drive and can only leave idle toward constant current.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_dvalid_reg) |->
            (m_drive_reg == '0) && (m_mode_reg == MODE_IDLE || m_mode_reg == MODE_CC))
        else $error("idle result carries a drive or a wrong mode");

    // Constant voltage is reached only through constant current.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_IDLE) |=> (mode_reg != MODE_CV))
        else $error("idle jumped straight to constant voltage");

    // Integrators change only when an item passes the control stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> ($stable(volt_integral_reg) && $stable(amp_integral_reg)))
        else $error("integrator changed without an item");

    // An empty result register never holds off the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_tready)
        else $error("input stalled with result register empty");

endmodule

`default_nettype wire

/* dv/cc_cv_charge_controller_tb.sv */
// Self-checking testbench for cc_cv_charge_controller: stream driver, result monitor
// and a cycle-free model of the CC/CV mode sequencer and its PI law.
// Depends on cccv_pkg and the cc_cv_charge_controller RTL.

module cc_cv_charge_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cccv_pkg::*;

    localparam int SAMPLE_BITS = 12;
    localparam int ACC_BITS    = 24;
    localparam int S_W         = ((2 * SAMPLE_BITS + 1 + 7) / 8) * 8;
    localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
    localparam int GAIN_MAX    = (1 << GAIN_BITS) - 1;
    localparam int CFG_ADDR_MAX = (1 << CFG_ADDR_BITS) - 1;

    // Register values after reset.
    localparam int RST_GAIN = 655;
    localparam int RST_VSET = 3300;
    localparam int RST_ASET = 1000;
    localparam int RST_IEND = 0;

    localparam int STALL_LEN   = 300;   // long receiver hold-off, in cycles
    localparam int WINDUP_LEN  = 100;   // long stretch of large current error
    localparam int MAX_REPORTS = 10;

    localparam logic [DRIVE_BITS-1:0] DRIVE_POS_SAT = {1'b0, {(DRIVE_BITS-1){1'b1}}};
    localparam logic [DRIVE_BITS-1:0] DRIVE_NEG_SAT = {1'b1, {(DRIVE_BITS-1){1'b0}}};

    // One input item; enable sits in bit 0 of s_tdata.
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] amp_sample;
        logic [SAMPLE_BITS-1:0] volt_sample;
        logic                   enable;
    } sample_t;

    // One result item; drive_value sits in the low bits of m_tdata.
    typedef struct packed {
        mode_t                  mode;
        logic                   drive_valid;
        logic [DRIVE_BITS-1:0]  drive_value;
    } drive_result_t;

    localparam int RES_W = $bits(drive_result_t);

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [S_W-1:0]           s_tdata   = '0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [M_DATA_W-1:0]      m_tdata;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_ADDR_BITS-1:0] cfg_addr  = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    cc_cv_charge_controller #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .ACC_BITS   (ACC_BITS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    // Model copy of the controller state and of its registers.
    mode_t  model_mode;
    longint volt_integ;
    longint amp_integ;
    longint gain_q16;
    longint volt_target;
    longint amp_target;
    longint end_amps;

    sample_t       pending_samples[$];   // items waiting for the driver
    drive_result_t results_due[$];       // predicted results, oldest first

    int items_queued   = 0;
    int items_accepted = 0;
    int results_checked = 0;
    int fail_count     = 0;
    int cfg_writes     = 0;
    int regulated_seen = 0;
    int cv_seen        = 0;
    int sat_seen       = 0;

    // Idle rates in percent, and the long hold-off request for the receiver.
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic stall_req     = 1'b0;
    int   stall_left    = 0;

    // 2 ns clock.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic longint clamp_signed(longint v, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Q0.16 proportional term, rounded to nearest with ties toward plus infinity.
    // The arithmetic shift of a signed value is a floor division.
    function automatic longint prop_term(longint err);
        return (gain_q16 * err + ROUND_HALF) >>> GAIN_BITS;
    endfunction

    // Advances the model by one accepted item and returns the result it causes.
    // The drive is worked out in the mode held before the item; the reported
    // mode is the one after it.
    function automatic drive_result_t charge_step(sample_t smp);
        drive_result_t res;
        longint        err;
        longint        drive;
        drive           = 0;
        res.drive_valid = 1'b0;
        case (model_mode)
            MODE_CC: begin
                err       = amp_target - longint'(smp.amp_sample);
                amp_integ = clamp_signed(amp_integ + err, ACC_BITS);
                drive     = clamp_signed(amp_target - prop_term(err) - amp_integ, DRIVE_BITS);
                res.drive_valid = 1'b1;
                if (longint'(smp.volt_sample) >= volt_target) model_mode = MODE_CV;
            end
            MODE_CV: begin
                err        = volt_target - longint'(smp.volt_sample);
                volt_integ = clamp_signed(volt_integ + err, ACC_BITS);
                drive      = clamp_signed(volt_target - prop_term(err) - volt_integ, DRIVE_BITS);
                res.drive_valid = 1'b1;
                if (longint'(smp.amp_sample) <= end_amps) model_mode = MODE_IDLE;
            end
            default: begin
                // Idle only decides the next mode; its result carries no drive.
                model_mode = smp.enable ? MODE_CC : MODE_IDLE;
            end
        endcase
        res.drive_value = drive[DRIVE_BITS-1:0];
        res.mode        = model_mode;
        return res;
    endfunction

    function automatic void apply_reg(logic [CFG_ADDR_BITS-1:0] addr,
                                      logic [CFG_DATA_BITS-1:0] data);
        case (addr)
            REG_PROP_GAIN:     gain_q16    = longint'(data);
            REG_VOLT_SETPOINT: volt_target = longint'(data[SAMPLE_BITS-1:0]);
            REG_AMP_SETPOINT:  amp_target  = longint'(data[SAMPLE_BITS-1:0]);
            REG_END_CURRENT:   end_amps    = longint'(data[SAMPLE_BITS-1:0]);
            default: ;  // unmapped indexes are dropped by the block
        endcase
    endfunction

    // Driver: predicts each item as it is accepted, then offers the next one.
    // tvalid is only lowered between items, never while one waits for tready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                results_due.push_back(charge_step(sample_t'(s_tdata[$bits(sample_t)-1:0])));
                items_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_samples.size() != 0 && int'($urandom_range(99)) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_W'(pending_samples.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off of the receiver, counted here so that the stimulus
    // process only has to request it.
    always @(posedge aclk) begin
        if (stall_req) begin
            stall_left <= STALL_LEN;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end
    end

    // Monitor: every accepted result is checked against the oldest prediction.
    always @(posedge aclk) begin : monitor
        drive_result_t got;
        drive_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = drive_result_t'(m_tdata[RES_W-1:0]);
                if (results_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result item: drive %0d valid %0d mode %0d",
                                 $signed(got.drive_value), got.drive_valid, got.mode);
                end else begin
                    want = results_due.pop_front();
                    results_checked++;
                    if (got.drive_value !== want.drive_value ||
                        got.drive_valid !== want.drive_valid || got.mode !== want.mode) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("result %0d mismatch: expected drive %0d valid %0d mode %0d",
                                     results_checked, $signed(want.drive_value),
                                     want.drive_valid, want.mode);
                            $display("    got drive %0d valid %0d mode %0d",
                                     $signed(got.drive_value), got.drive_valid, got.mode);
                        end
                    end
                    if (want.drive_valid) regulated_seen++;
                    if (want.mode == MODE_CV) cv_seen++;
                    if (want.drive_value == DRIVE_POS_SAT || want.drive_value == DRIVE_NEG_SAT)
                        sat_seen++;
                end
            end
            m_tready <= (stall_left == 0) && !stall_req &&
                        (int'($urandom_range(99)) >= recv_idle_pct);
        end
    end

    function automatic int rnd(int hi);
        return int'($urandom_range(hi));
    endfunction

    function automatic int jitter(int span);
        return rnd(2 * span) - span;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] clip_sample(int v);
        if (v < 0) return '0;
        if (v > SAMPLE_MAX) return SAMPLE_MAX[SAMPLE_BITS-1:0];
        return v[SAMPLE_BITS-1:0];
    endfunction

    // Called at a falling edge, so the driver never races the queue.
    task automatic queue_sample(logic en, int volt, int amp);
        sample_t smp;
        smp.enable      = en;
        smp.volt_sample = clip_sample(volt);
        smp.amp_sample  = clip_sample(amp);
        pending_samples.push_back(smp);
        items_queued++;
    endtask

    task automatic write_reg(logic [CFG_ADDR_BITS-1:0] addr, logic [CFG_DATA_BITS-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(addr, data);
        cfg_writes++;
        cfg_valid <= 1'b0;
    endtask

    // Writes all four registers. The upper bits of the 12 bit registers get
    // random values, which the block must mask off; an unmapped index is
    // written too and must change nothing.
    task automatic write_setting(int gain, int vset, int aset, int iend);
        logic [CFG_DATA_BITS-1:0] data;
        write_reg(REG_PROP_GAIN, gain[CFG_DATA_BITS-1:0]);
        data = CFG_DATA_BITS'($urandom);
        data[SAMPLE_BITS-1:0] = vset[SAMPLE_BITS-1:0];
        write_reg(REG_VOLT_SETPOINT, data);
        data = CFG_DATA_BITS'($urandom);
        data[SAMPLE_BITS-1:0] = aset[SAMPLE_BITS-1:0];
        write_reg(REG_AMP_SETPOINT, data);
        data = CFG_DATA_BITS'($urandom);
        data[SAMPLE_BITS-1:0] = iend[SAMPLE_BITS-1:0];
        write_reg(REG_END_CURRENT, data);
        write_reg(CFG_ADDR_BITS'($urandom_range(CFG_ADDR_MAX, REG_END_CURRENT + 1)),
                  CFG_DATA_BITS'($urandom));
        @(negedge aclk);
    endtask

    task automatic typical_setting();
        write_setting(rnd(GAIN_MAX), 2500 + rnd(SAMPLE_MAX - 2500), 200 + rnd(2800), rnd(300));
    endtask

    // The block is idle once nothing is queued, offered or outstanding.
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_samples.size() != 0 || s_tvalid || results_due.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    // One charge cycle with random content: start request, current ramp up to
    // the voltage setpoint, voltage hold while the current decays, and
    // termination at the end current, followed by a short idle gap.
    task automatic queue_session();
        int cc_len;
        int cv_len;
        int vt;
        int at;
        int et;
        int i;
        cc_len = 2 + rnd(28);
        cv_len = 2 + rnd(28);
        vt = int'(volt_target);
        at = int'(amp_target);
        et = int'(end_amps);
        queue_sample(1'b1, rnd(vt / 2), rnd(SAMPLE_MAX));
        for (i = 0; i < cc_len; i++)
            queue_sample(1'(rnd(1)), vt * i / cc_len - rnd(20), at + jitter(64));
        queue_sample(1'(rnd(1)), vt + rnd(30), at + jitter(64));
        for (i = 0; i < cv_len; i++)
            queue_sample(1'(rnd(1)), vt + jitter(32),
                         et + 1 + (at - et) * (cv_len - i) / cv_len + rnd(40));
        queue_sample(1'(rnd(1)), vt + jitter(32), et - rnd(20));
        repeat (rnd(3)) queue_sample(1'b0, rnd(SAMPLE_MAX), rnd(SAMPLE_MAX));
    endtask

    // Mostly well-formed charge cycles, with some fully random items mixed in.
    task automatic queue_random(int n);
        int start;
        start = items_queued;
        while (items_queued - start < n) begin
            if (rnd(99) < 15) begin
                repeat (1 + rnd(3)) queue_sample(1'(rnd(1)), rnd(SAMPLE_MAX), rnd(SAMPLE_MAX));
            end else begin
                queue_session();
            end
        end
    endtask

    initial begin
        model_mode  = MODE_IDLE;
        volt_integ  = 0;
        amp_integ   = 0;
        gain_q16    = RST_GAIN;
        volt_target = RST_VSET;
        amp_target  = RST_ASET;
        end_amps    = RST_IEND;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed checks with the reset register values.
        queue_sample(1'b0, SAMPLE_MAX, SAMPLE_MAX);   // idle stays idle without enable
        queue_sample(1'b0, 0, 0);
        queue_sample(1'b1, 0, 0);                     // start: no drive on this item
        queue_sample(1'b1, 0, 0);                     // full positive current error
        queue_sample(1'b0, 0, SAMPLE_MAX);            // large negative current error
        queue_sample(1'b1, RST_VSET - 1, RST_ASET);   // one below the voltage setpoint
        queue_sample(1'b0, RST_VSET, 2000);           // voltage equals setpoint: to CV
        queue_sample(1'b1, SAMPLE_MAX, SAMPLE_MAX);   // enable is ignored in CV
        queue_sample(1'b0, 0, 1);
        queue_sample(1'b0, RST_VSET, 0);              // current equals end current: to idle
        queue_sample(1'b0, SAMPLE_MAX, SAMPLE_MAX);
        wait_drained();

        // Largest gain, setpoints at both ends: CC hands over at once.
        write_setting(GAIN_MAX, 0, SAMPLE_MAX, SAMPLE_MAX);
        queue_sample(1'b1, SAMPLE_MAX, SAMPLE_MAX);
        queue_sample(1'b0, 0, 0);
        queue_sample(1'b0, SAMPLE_MAX, SAMPLE_MAX);
        wait_drained();

        // Half gain: errors of plus and minus one land on rounding ties.
        write_setting(32768, 2048, 2047, 100);
        queue_sample(1'b1, 0, 0);
        queue_sample(1'b0, 0, 2046);
        queue_sample(1'b0, 0, 2048);
        queue_sample(1'b0, 0, 2045);
        queue_sample(1'b0, 2048, 2049);
        queue_sample(1'b0, 2049, 100);
        wait_drained();

        // Sender idles rarely, receiver often.
        send_idle_pct = 10;
        recv_idle_pct = 56;
        typical_setting();
        queue_random(120);
        wait_drained();
        write_setting(0, SAMPLE_MAX, SAMPLE_MAX, 0);
        queue_random(120);
        wait_drained();

        // The other way round.
        send_idle_pct = 56;
        recv_idle_pct = 10;
        typical_setting();
        queue_random(120);
        wait_drained();
        write_setting(GAIN_MAX, 0, 0, SAMPLE_MAX);
        queue_random(120);
        wait_drained();

        // No idling. A long hold-off of the receiver lets the block fill up
        // while the sender keeps offering items.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_setting(rnd(GAIN_MAX), rnd(SAMPLE_MAX), rnd(SAMPLE_MAX), rnd(SAMPLE_MAX));
        queue_random(120);
        @(negedge aclk);
        stall_req = 1'b1;
        @(negedge aclk);
        stall_req = 1'b0;
        wait_drained();

        // Integrator windup: a long CC stretch with a large negative current
        // error winds the current integrator far from zero.
        write_setting(GAIN_MAX, SAMPLE_MAX, 0, 0);
        queue_sample(1'b0, SAMPLE_MAX - 95, 0);       // leaves CV if the block is there
        queue_sample(1'b1, 0, 0);                     // leaves idle if the block is there
        repeat (WINDUP_LEN)
            queue_sample(1'(rnd(1)), rnd(SAMPLE_MAX - 1), 3900 + rnd(SAMPLE_MAX - 3900));
        queue_sample(1'b0, SAMPLE_MAX, SAMPLE_MAX);
        repeat (20) queue_sample(1'(rnd(1)), rnd(SAMPLE_MAX), 1 + rnd(SAMPLE_MAX - 1));
        queue_sample(1'b0, rnd(SAMPLE_MAX), 0);
        wait_drained();

        typical_setting();
        queue_random(80);
        wait_drained();

        $display("covered %0d sample items, %0d result items and %0d register writes",
                 items_accepted, results_checked, cfg_writes);
        $display("results with drive %0d, in constant voltage %0d, saturated drive %0d",
                 regulated_seen, cv_seen, sat_seen);
        if (fail_count == 0 && results_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #400000;
        $display("timeout with %0d result items outstanding", results_due.size());
        $display("status: fail");
        $finish;
    end

endmodule
